/* src/ifr_pkg.sv */
// ---------------------------------------------------------------------------
// ifr_pkg
// Shared types and constants of the image frame reassembler.
// ---------------------------------------------------------------------------
package ifr_pkg;

	localparam int BYTE_W  = 8;
	localparam int ADDR_W  = 14;
	localparam int POS_W   = 7;
	localparam int TIMER_W = 16;
	localparam int CFG_W   = 16;

	localparam logic [BYTE_W-1:0] KIND_DATA = 8'hB1;
	localparam logic [BYTE_W-1:0] KIND_DONE = 8'hB2;

	localparam logic [CFG_W-1:0] IDLE_RST  = 16'd25000;
	localparam logic [CFG_W-1:0] HARD_RST  = 16'd60000;
	localparam logic [CFG_W-1:0] GRACE_RST = 16'd3000;

	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_BYTE  = 2'd1,
		FUNC_TICK  = 2'd2,
		FUNC_READ  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		EV_FRAME   = 2'd0,
		EV_SUCCESS = 2'd1,
		EV_FAIL    = 2'd2,
		EV_READ    = 2'd3
	} ev_t;

	typedef enum logic [1:0] {
		CFG_IDLE  = 2'd0,
		CFG_HARD  = 2'd1,
		CFG_GRACE = 2'd2
	} cfg_idx_t;

	// classified item, front to back
	typedef struct packed {
		func_t             func;
		logic              tot_ok;   // start count within 1..MAX_FRAMES
		logic [BYTE_W-1:0] data;     // announced total or frame byte
		logic              last;
		logic [ADDR_W-1:0] addr;
		logic              addr_ok;  // read address inside the store
	} item_t;

	typedef struct packed {
		ev_t               ev;
		logic [BYTE_W-1:0] frames_got;
		logic [BYTE_W-1:0] frames_total;
		logic [ADDR_W-1:0] image_len;
		logic [BYTE_W-1:0] read_data;
	} res_t;

endpackage

/* src/ifr_fifo.sv */
// ---------------------------------------------------------------------------
// ifr_fifo
// Small register FIFO with fill level, used between front and back and on
// the result side.
// ---------------------------------------------------------------------------
module ifr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int LW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data,
	output logic [LW-1:0]    level
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [LW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != LW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign level      = cnt_q;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + LW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - LW'(1);
			end
		end
	end

endmodule

/* src/ifr_front.sv */
// ---------------------------------------------------------------------------
// ifr_front
// Input stage: takes items from the stream, decodes the function and the
// range checks, and hands classified items to the queue.
// ---------------------------------------------------------------------------
module ifr_front #(
	parameter int MAX_FRAMES = 200,
	parameter int MAX_BYTES  = 11400
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    in_func,
	input  logic [ifr_pkg::BYTE_W-1:0]    in_total,
	input  logic [ifr_pkg::BYTE_W-1:0]    in_byte,
	input  logic                          in_last,
	input  logic [ifr_pkg::ADDR_W-1:0]    in_addr,
	output ifr_pkg::item_t                item,
	output logic                          item_valid,
	input  logic                          item_ready
);
	import ifr_pkg::*;

	item_t cls;
	item_t item_s1;
	logic  v_s1;

	always_comb begin
		cls.func    = func_t'(in_func);
		cls.tot_ok  = (in_total != '0) && (in_total <= BYTE_W'(MAX_FRAMES));
		cls.data    = (func_t'(in_func) == FUNC_START) ? in_total : in_byte;
		cls.last    = in_last;
		cls.addr    = in_addr;
		cls.addr_ok = (in_addr < ADDR_W'(MAX_BYTES));
	end

	assign in_ready   = !v_s1 || item_ready;
	assign item_valid = v_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= cls;
		end
	end

endmodule

/* src/ifr_back.sv */
// ---------------------------------------------------------------------------
// ifr_back
// Execution side: session state, frame parser, seen bitmap, image store and
// the payload copy sequencer. One queued item per cycle with output room; a
// stored frame holds the queue while its payload goes to the image store.
// ---------------------------------------------------------------------------
module ifr_back #(
	parameter int CHUNK_BYTES     = 57,
	parameter int MAX_FRAMES      = 200,
	parameter int MAX_BYTES       = 11400,
	parameter int FRAME_BUF_BYTES = 64,
	parameter int OUT_DEPTH       = 4,
	localparam int LW = $clog2(OUT_DEPTH + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_addr,
	input  logic [ifr_pkg::CFG_W-1:0]  cfg_wdata,
	input  ifr_pkg::item_t             q_item,
	input  logic                       q_valid,
	output logic                       q_pop,
	input  logic [LW-1:0]              out_level,
	output ifr_pkg::res_t              res_data,
	output logic                       res_valid
);
	import ifr_pkg::*;

	localparam int PB_DEPTH = FRAME_BUF_BYTES - 3;
	localparam int PB_W     = (PB_DEPTH > 1) ? $clog2(PB_DEPTH) : 1;
	localparam int CH_W     = $clog2(CHUNK_BYTES + 1);
	localparam int SEEN_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int IMG_AW   = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

	typedef enum logic {
		ST_RUN,
		ST_COPY
	} state_t;

	state_t st_q;

	logic [CFG_W-1:0]   idle_q, hard_q, grace_q;
	logic               open_q;
	logic [BYTE_W-1:0]  total_q, cnt_q;
	logic [ADDR_W-1:0]  len_q;
	logic [TIMER_W-1:0] ss_q, sf_q;
	logic [POS_W-1:0]   pos_q;
	logic [BYTE_W-1:0]  kind_q, idx_q, dtot_q;
	logic [ADDR_W-1:0]  off_q;
	logic [MAX_FRAMES-1:0] seen_q;

	logic [PB_W-1:0]    cp_src_q;
	logic [CH_W-1:0]    cp_left_q;
	logic [ADDR_W-1:0]  cp_dst_q;
	logic               wr_v_s1;
	logic [ADDR_W-1:0]  wr_addr_s1;

	logic               res_v_s1;
	res_t               res_s1;
	logic               rd_ok_s1;

	logic [BYTE_W-1:0]  img_mem [MAX_BYTES];
	logic [BYTE_W-1:0]  img_rd_q;
	logic [BYTE_W-1:0]  pb_mem [PB_DEPTH];
	logic [BYTE_W-1:0]  pb_rd_q;

	// decode of the current item
	logic               room;
	logic [BYTE_W-1:0]  b;
	logic               pos_ok;
	logic [POS_W-1:0]   pos_n;
	logic [POS_W-1:0]   pb_waddr;
	logic               pb_we;
	logic [BYTE_W-1:0]  kind_e, idx_e, dtot_e;
	logic [ADDR_W-1:0]  off_n;
	logic               data_ok;
	logic [POS_W-1:0]   pay_len;
	logic [CH_W-1:0]    chunk;
	logic [ADDR_W-1:0]  end_a;
	logic               fits;
	logic               seen_hit;
	logic               store;
	logic [BYTE_W-1:0]  cnt_n;
	logic [ADDR_W-1:0]  len_n;
	logic               complete_n;
	logic               complete_q;
	logic               is_done;
	logic               frame_fin;
	logic [TIMER_W-1:0] ss_n, sf_n;
	logic               tick_fin;
	logic               res_emit;
	res_t               res_n;

	always_comb begin
		room     = ({1'b0, out_level} + (LW + 1)'(res_v_s1)) < (LW + 1)'(OUT_DEPTH);
		q_pop    = (st_q == ST_RUN) && q_valid && room;
		b        = q_item.data;
		pos_ok   = pos_q < POS_W'(FRAME_BUF_BYTES);
		pos_n    = pos_ok ? pos_q + POS_W'(1) : pos_q;
		pb_waddr = pos_q - POS_W'(3);
		pb_we    = q_pop && (q_item.func == FUNC_BYTE) && open_q && pos_ok
		           && (pos_q >= POS_W'(3));
		// header bytes may land in this very cycle
		kind_e   = (pos_q == POS_W'(0)) ? b : kind_q;
		idx_e    = (pos_q == POS_W'(1)) ? b : idx_q;
		dtot_e   = (pos_q == POS_W'(2)) ? b : dtot_q;
		off_n    = ADDR_W'(b) * ADDR_W'(CHUNK_BYTES);

		data_ok  = (pos_n >= POS_W'(3)) && (kind_e == KIND_DATA) && (dtot_e != '0)
		           && (dtot_e <= BYTE_W'(MAX_FRAMES)) && (idx_e < dtot_e);
		pay_len  = pos_n - POS_W'(3);
		chunk    = (pay_len > POS_W'(CHUNK_BYTES)) ? CH_W'(CHUNK_BYTES) : pay_len[CH_W-1:0];
		// offset was latched with the index byte, always before a data frame ends
		end_a    = off_q + ADDR_W'(chunk);
		fits     = end_a <= ADDR_W'(MAX_BYTES);
		seen_hit = seen_q[idx_e[SEEN_W-1:0]];
		store    = data_ok && fits && !seen_hit;
		cnt_n    = cnt_q + BYTE_W'(store && (idx_e < total_q));
		len_n    = (store && ((idx_e == dtot_e - BYTE_W'(1)) || (end_a > len_q))) ? end_a : len_q;
		complete_n = (total_q != '0) && (cnt_n == total_q);
		complete_q = (total_q != '0) && (cnt_q == total_q);
		is_done  = (kind_e == KIND_DONE);
		frame_fin = (data_ok && complete_n) || (is_done && (complete_q || (ss_q > grace_q)));

		ss_n     = (ss_q == '1) ? ss_q : ss_q + TIMER_W'(1);
		sf_n     = (sf_q == '1) ? sf_q : sf_q + TIMER_W'(1);
		tick_fin = (sf_n > idle_q) || (ss_n > hard_q);

		res_emit = 1'b0;
		res_n.ev           = EV_FRAME;
		res_n.frames_got   = cnt_q;
		res_n.frames_total = total_q;
		res_n.image_len    = len_q;
		res_n.read_data    = '0;
		case (q_item.func)
			FUNC_BYTE: begin
				res_emit = open_q && q_item.last;
				res_n.frames_got = cnt_n;
				res_n.image_len  = len_n;
				if (frame_fin) begin
					res_n.ev = (complete_n && (len_n != '0)) ? EV_SUCCESS : EV_FAIL;
				end
			end
			FUNC_TICK: begin
				res_emit = open_q && tick_fin;
				res_n.ev = (complete_q && (len_q != '0)) ? EV_SUCCESS : EV_FAIL;
			end
			FUNC_READ: begin
				res_emit = 1'b1;
				res_n.ev = EV_READ;
			end
			default: begin
				res_emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_RUN;
			idle_q     <= IDLE_RST;
			hard_q     <= HARD_RST;
			grace_q    <= GRACE_RST;
			open_q     <= 1'b0;
			total_q    <= '0;
			cnt_q      <= '0;
			len_q      <= '0;
			ss_q       <= '0;
			sf_q       <= '0;
			pos_q      <= '0;
			kind_q     <= '0;
			idx_q      <= '0;
			dtot_q     <= '0;
			off_q      <= '0;
			seen_q     <= '0;
			cp_src_q   <= '0;
			cp_left_q  <= '0;
			cp_dst_q   <= '0;
			wr_v_s1    <= 1'b0;
			wr_addr_s1 <= '0;
			res_v_s1   <= 1'b0;
		end else begin
			res_v_s1 <= q_pop && res_emit;
			wr_v_s1  <= 1'b0;

			if (cfg_we) begin
				case (cfg_idx_t'(cfg_addr))
					CFG_IDLE:  idle_q  <= cfg_wdata;
					CFG_HARD:  hard_q  <= cfg_wdata;
					CFG_GRACE: grace_q <= cfg_wdata;
					default:   ;
				endcase
			end

			case (st_q)
				ST_COPY: begin
					if (cp_left_q != '0) begin
						wr_v_s1    <= 1'b1;
						wr_addr_s1 <= cp_dst_q;
						cp_src_q   <= cp_src_q + PB_W'(1);
						cp_dst_q   <= cp_dst_q + ADDR_W'(1);
						cp_left_q  <= cp_left_q - CH_W'(1);
					end else begin
						// last write lands at this edge
						st_q <= ST_RUN;
					end
				end
				default: begin
					if (q_pop) begin
						case (q_item.func)
							FUNC_START: begin
								if (!open_q && q_item.tot_ok) begin
									seen_q  <= '0;
									cnt_q   <= '0;
									total_q <= q_item.data;
									len_q   <= '0;
									ss_q    <= '0;
									sf_q    <= '0;
									pos_q   <= '0;
									open_q  <= 1'b1;
								end
							end
							FUNC_BYTE: begin
								if (!open_q) begin
									pos_q <= '0;
								end else begin
									if (pos_q == POS_W'(0)) begin
										kind_q <= b;
									end
									if (pos_q == POS_W'(1)) begin
										idx_q <= b;
										off_q <= off_n;
									end
									if (pos_q == POS_W'(2)) begin
										dtot_q <= b;
									end
									if (!q_item.last) begin
										pos_q <= pos_n;
									end else begin
										pos_q <= '0;
										cnt_q <= cnt_n;
										len_q <= len_n;
										if (data_ok || is_done) begin
											sf_q <= '0;
										end
										if (store) begin
											seen_q[idx_e[SEEN_W-1:0]] <= 1'b1;
											if (chunk != '0) begin
												st_q      <= ST_COPY;
												cp_src_q  <= '0;
												cp_left_q <= chunk;
												cp_dst_q  <= off_q;
											end
										end
										if (frame_fin) begin
											open_q <= 1'b0;
										end
									end
								end
							end
							FUNC_TICK: begin
								if (open_q) begin
									ss_q <= ss_n;
									sf_q <= sf_n;
									if (tick_fin) begin
										open_q <= 1'b0;
										pos_q  <= '0;
									end
								end
							end
							default: ;
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_s1   <= res_n;
			rd_ok_s1 <= (q_item.func == FUNC_READ) && q_item.addr_ok;
		end
	end

	// payload buffer of the frame in progress
	always_ff @(posedge clk) begin
		if (pb_we) begin
			pb_mem[pb_waddr[PB_W-1:0]] <= b;
		end
	end

	always_ff @(posedge clk) begin
		if ((st_q == ST_COPY) && (cp_left_q != '0)) begin
			pb_rd_q <= pb_mem[cp_src_q];
		end
	end

	// image store
	always_ff @(posedge clk) begin
		if (wr_v_s1) begin
			img_mem[wr_addr_s1[IMG_AW-1:0]] <= pb_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && (q_item.func == FUNC_READ) && q_item.addr_ok) begin
			img_rd_q <= img_mem[q_item.addr[IMG_AW-1:0]];
		end
	end

	always_comb begin
		res_data           = res_s1;
		res_data.read_data = rd_ok_s1 ? img_rd_q : '0;
	end
	assign res_valid = res_v_s1;

endmodule

/* src/image_frame_reassembler.sv */
// ---------------------------------------------------------------------------
// image_frame_reassembler
// Rebuilds an image from radio frame bytes with a seen-frame bitmap.
// ---------------------------------------------------------------------------
// Usage:
//   Items enter on s_axis: tuser selects start, frame byte, 1 ms tick or
//   store read; tlast marks the last byte of a radio frame. Results leave on
//   m_axis, at most one per item: tuser is the event, tdata the counters,
//   image length and read byte. Registers are written through cfg_we,
//   cfg_addr and cfg_wdata; the user must write them only while the block
//   is idle, which the block itself does not enforce.
//   Throughput: one item per cycle unless held. A newly stored data frame
//   holds the back end while its payload moves from the frame buffer to the
//   single-port image store; items keep entering the queue meanwhile.
//   Reset: session closed, counters and timers zero, registers at their
//   defaults, image store left uninitialized (no clearing pass).
//   Receiver stall: results collect in a four-entry output queue; when it is
//   full the back end stops, the input queue fills and s_axis_tready drops.
// ---------------------------------------------------------------------------
module image_frame_reassembler #(
	parameter int CHUNK_BYTES     = 57,
	parameter int MAX_FRAMES      = 200,
	parameter int MAX_BYTES       = 11400,
	parameter int FRAME_BUF_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // announced_total, rx_byte, read_addr, pad
	input  logic [1:0]  s_axis_tuser,   // func
	input  logic        s_axis_tlast,   // frame_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // frames_got, frames_total, image_len, read_data, pad
	output logic [1:0]  m_axis_tuser,   // event_res
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import ifr_pkg::*;

	localparam int Q_DEPTH   = 4;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_LW    = $clog2(OUT_DEPTH + 1);
	localparam int Q_LW      = $clog2(Q_DEPTH + 1);

	item_t             f_item;
	logic              f_valid, f_ready;
	logic [$bits(item_t)-1:0] q_data;
	item_t             q_item;
	logic              q_valid, q_pop;
	logic [Q_LW-1:0]   q_level;
	res_t              b_res;
	logic              b_valid;
	logic              o_ready;
	logic [$bits(res_t)-1:0] o_data;
	res_t              o_res;
	logic [OUT_LW-1:0] o_level;

	ifr_front #(
		.MAX_FRAMES (MAX_FRAMES),
		.MAX_BYTES  (MAX_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_func    (s_axis_tuser),
		.in_total   (s_axis_tdata[7:0]),
		.in_byte    (s_axis_tdata[15:8]),
		.in_last    (s_axis_tlast),
		.in_addr    (s_axis_tdata[29:16]),
		.item       (f_item),
		.item_valid (f_valid),
		.item_ready (f_ready)
	);

	ifr_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_pop),
		.pop_data   (q_data),
		.level      (q_level)
	);

	assign q_item = item_t'(q_data);

	ifr_back #(
		.CHUNK_BYTES     (CHUNK_BYTES),
		.MAX_FRAMES      (MAX_FRAMES),
		.MAX_BYTES       (MAX_BYTES),
		.FRAME_BUF_BYTES (FRAME_BUF_BYTES),
		.OUT_DEPTH       (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.q_item    (q_item),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.out_level (o_level),
		.res_data  (b_res),
		.res_valid (b_valid)
	);

	ifr_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (b_valid),
		.push_ready (o_ready),
		.push_data  (b_res),
		.pop_valid  (m_axis_tvalid),
		.pop_ready  (m_axis_tready),
		.pop_data   (o_data),
		.level      (o_level)
	);

	assign o_res        = res_t'(o_data);
	assign m_axis_tuser = o_res.ev;
	assign m_axis_tdata = {2'b00, o_res.read_data, o_res.image_len,
	                       o_res.frames_total, o_res.frames_got};

	// a result from the back end always finds room in the output queue
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		b_valid |-> o_ready)
		else $error("result lost: output queue full");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (q_valid && (q_level != '0)))
		else $error("back end popped an empty queue");

	a_got_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (o_res.frames_got <= o_res.frames_total))
		else $error("frame count above session total");

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (o_res.image_len <= ADDR_W'(MAX_BYTES)))
		else $error("image length beyond store size");

endmodule
